/* rtl/mts_pkg.sv */
// Shared package for the min-tracking stack.
// Holds the default depth, data width, operation and status codes, FSM states.
// No dependencies.
package mts_pkg;

  localparam int unsigned MTS_STACK_DEPTH = 64;
  localparam int unsigned MTS_DATA_W      = 32;

  // Operation kind carried by each input transfer
  localparam logic MTS_KIND_PUSH = 1'b0;
  localparam logic MTS_KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    MTS_STATUS_OK    = 2'd0,
    MTS_STATUS_FULL  = 2'd1,
    MTS_STATUS_EMPTY = 2'd2
  } mts_status_e;

  typedef enum logic {
    MTS_ST_IDLE   = 1'b0,
    MTS_ST_POP_RD = 1'b1
  } mts_state_e;

endpackage

/* rtl/mts_if.sv */
// Valid/ready channel interfaces for the min-tracking stack.
// Depends on mts_pkg for widths and the status type.
interface mts_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [mts_pkg::MTS_DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface mts_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mts_pkg::MTS_DATA_W-1:0] top_value;
  logic signed [mts_pkg::MTS_DATA_W-1:0] min_value;
  logic                                  is_empty;
  mts_pkg::mts_status_e                  status;

  modport source (output valid, top_value, min_value, is_empty, status, input ready);
  modport sink   (input valid, top_value, min_value, is_empty, status, output ready);
endinterface

/* rtl/min_tracking_stack_top.sv */
// Top level of the min-tracking stack: core control plus entry RAM.
// Depends on mts_pkg, mts_if, mts_ram and mts_core.
//
// A bounded LIFO of signed 32-bit values that also reports the minimum of its
// contents. Each input transfer is a push (kind 0, carries value) or a pop
// (kind 1). Every input transfer yields exactly one output transfer with the
// new top, the new minimum (both zero when empty), an empty flag and a status:
// OK, push refused because full, or pop refused because empty. A refused
// operation leaves the stack unchanged. Each RAM entry stores a value together
// with the minimum of that entry and everything below it, so a pop restores the
// previous minimum directly. The current top and minimum live in registers.
// A push, a refused operation, or a pop that empties the stack gives a valid
// result in the cycle after the input transfer; a pop that leaves entries
// behind goes through the RAM read register, which refills the top registers,
// then the output register. One item is in flight at a time; the next
// input transfer is taken in the same cycle the pending result is transferred
// out. Storage: STACK_DEPTH entries of 64 bits; no clearing pass after reset.
module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = mts_pkg::MTS_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mts_in_if.sink    in_i,
  mts_out_if.source out_o
);
  import mts_pkg::*;

  localparam int unsigned AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned EntryW = 2 * MTS_DATA_W;

  // RAM port between control and storage
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  // Sequence operations, hold top/minimum, drive the output register
  mts_core #(
    .StackDepth (STACK_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Store {value, running minimum} per stack slot
  mts_ram #(
    .Depth (STACK_DEPTH),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* rtl/mts_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies.
module mts_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mts_core.sv */
// Control for the min-tracking stack: entry count, top/minimum registers,
// pop refill from RAM and the output register. Depends on mts_pkg, mts_if.
module mts_core #(
  parameter int unsigned StackDepth = mts_pkg::MTS_STACK_DEPTH,
  localparam int unsigned AddrW  = (StackDepth > 1) ? $clog2(StackDepth) : 1,
  localparam int unsigned CountW = $clog2(StackDepth + 1),
  localparam int unsigned EntryW = 2 * mts_pkg::MTS_DATA_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mts_in_if.sink            in_i,
  mts_out_if.source         out_o,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_waddr_o,
  output logic [EntryW-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  input  logic [EntryW-1:0] ram_rdata_i
);
  import mts_pkg::*;

  localparam logic [CountW-1:0] FullCount = CountW'(StackDepth);
  localparam logic [CountW-1:0] OneCount  = CountW'(1);
  localparam logic [CountW-1:0] TwoCount  = CountW'(2);

  mts_state_e               state_q, state_d;
  logic [CountW-1:0]        count_q, count_d;
  logic signed [MTS_DATA_W-1:0] top_q, top_d;
  logic signed [MTS_DATA_W-1:0] min_q, min_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [MTS_DATA_W-1:0] out_top_q, out_top_d;
  logic signed [MTS_DATA_W-1:0] out_min_q, out_min_d;
  logic                     out_empty_q, out_empty_d;
  mts_status_e              out_status_q, out_status_d;

  logic                     out_free;
  logic                     accept;
  logic signed [MTS_DATA_W-1:0] push_min;
  logic [CountW-1:0]        below_idx;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == MTS_ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;

  // Keep the older minimum on ties
  assign push_min  = ((count_q != '0) && (min_q <= in_i.value)) ? min_q : in_i.value;
  assign below_idx = count_q - TwoCount;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    top_d        = top_q;
    min_d        = min_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_top_d    = out_top_q;
    out_min_d    = out_min_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = count_q[AddrW-1:0];
    ram_wdata_o  = {in_i.value, push_min};
    ram_re_o     = 1'b0;
    ram_raddr_o  = below_idx[AddrW-1:0];

    case (state_q)
      MTS_ST_IDLE: begin
        if (accept) begin
          if (in_i.kind == MTS_KIND_PUSH) begin
            out_valid_d = 1'b1;
            if (count_q == FullCount) begin
              out_top_d    = top_q;
              out_min_d    = min_q;
              out_empty_d  = 1'b0;
              out_status_d = MTS_STATUS_FULL;
            end else begin
              ram_we_o     = 1'b1;
              count_d      = count_q + OneCount;
              top_d        = in_i.value;
              min_d        = push_min;
              out_top_d    = in_i.value;
              out_min_d    = push_min;
              out_empty_d  = 1'b0;
              out_status_d = MTS_STATUS_OK;
            end
          end else begin
            if (count_q == '0) begin
              out_valid_d  = 1'b1;
              out_top_d    = '0;
              out_min_d    = '0;
              out_empty_d  = 1'b1;
              out_status_d = MTS_STATUS_EMPTY;
            end else if (count_q == OneCount) begin
              count_d      = '0;
              out_valid_d  = 1'b1;
              out_top_d    = '0;
              out_min_d    = '0;
              out_empty_d  = 1'b1;
              out_status_d = MTS_STATUS_OK;
            end else begin
              // Fetch the entry that becomes the new top
              count_d  = count_q - OneCount;
              ram_re_o = 1'b1;
              state_d  = MTS_ST_POP_RD;
            end
          end
        end
      end
      MTS_ST_POP_RD: begin
        top_d        = ram_rdata_i[EntryW-1:MTS_DATA_W];
        min_d        = ram_rdata_i[MTS_DATA_W-1:0];
        out_valid_d  = 1'b1;
        out_top_d    = ram_rdata_i[EntryW-1:MTS_DATA_W];
        out_min_d    = ram_rdata_i[MTS_DATA_W-1:0];
        out_empty_d  = 1'b0;
        out_status_d = MTS_STATUS_OK;
        state_d      = MTS_ST_IDLE;
      end
      default: begin
        state_d = MTS_ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= MTS_ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    min_q        <= min_d;
    out_top_q    <= out_top_d;
    out_min_q    <= out_min_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = out_top_q;
  assign out_o.min_value = out_min_q;
  assign out_o.is_empty  = out_empty_q;
  assign out_o.status    = out_status_q;

endmodule

/* rtl/mts_checker.sv */
// Port-level checks for the min-tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack_top.
module mts_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [mts_pkg::MTS_DATA_W-1:0] out_top_i,
  input logic signed [mts_pkg::MTS_DATA_W-1:0] out_min_i,
  input logic                                  out_empty_i,
  input mts_pkg::mts_status_e                  out_status_i
);
  import mts_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_top_i)
      && $stable(out_min_i) && $stable(out_empty_i) && $stable(out_status_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_top_i == '0 && out_min_i == '0)
    else $error("empty result with nonzero top or minimum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_empty_i |-> out_min_i <= out_top_i)
    else $error("minimum above top");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == MTS_STATUS_EMPTY |-> out_empty_i)
    else $error("refused pop on nonempty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == MTS_STATUS_FULL |-> !out_empty_i)
    else $error("refused push on empty stack");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_top_i    (out_o.top_value),
  .out_min_i    (out_o.min_value),
  .out_empty_i  (out_o.is_empty),
  .out_status_i (out_o.status)
);

/* tb/tb_min_tracking_stack_top.sv */
`timescale 1ns / 1ps
// Testbench for min_tracking_stack_top: a table of directed pushes and pops, then random phases.
// Each result is checked against a shadow stack that keeps a running minimum per entry.
// Depends on mts_pkg, mts_if and the min_tracking_stack_top RTL.
module tb_min_tracking_stack_top;
  import mts_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1080;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned IDLE_PERCENT  = 19;
  // Window of transfers with no idling on either side
  localparam int unsigned CALM_FIRST    = 250;
  localparam int unsigned CALM_LAST     = 450;
  // Long receiver hold-off while the sender keeps offering items
  localparam int unsigned HOLD_AT_ITEM  = 600;
  localparam int unsigned HOLD_CYCLES   = 300;
  // Sender pause until every pending result has come back
  localparam int unsigned PAUSE_AT_ITEM = 800;
  localparam int unsigned NUM_ROWS      = 22;
  localparam int unsigned MAX_REPORTS   = 40;

  localparam logic signed [MTS_DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [MTS_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [MTS_DATA_W-1:0] VAL_NEG = 32'shFFFF_FFFF;

  typedef struct packed {
    logic signed [MTS_DATA_W-1:0] top_value;
    logic signed [MTS_DATA_W-1:0] min_value;
    logic                         is_empty;
    mts_status_e                  status;
  } stack_result_t;

  // One directed row; known_result marks rows whose expectation is typed in
  typedef struct packed {
    logic                         kind;
    logic signed [MTS_DATA_W-1:0] value;
    logic                         known_result;
    stack_result_t                result;
  } stack_row_t;

  typedef enum logic [2:0] {
    PH_PUSH_HEAVY,
    PH_POP_HEAVY,
    PH_MIXED,
    PH_TO_FULL,
    PH_TO_EMPTY
  } phase_e;

  logic clk_i;
  logic rst_ni;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  min_tracking_stack_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the stack: each entry holds its value and the minimum at and below it
  logic signed [MTS_DATA_W-1:0] shadow_values   [MTS_STACK_DEPTH];
  logic signed [MTS_DATA_W-1:0] shadow_minimums [MTS_STACK_DEPTH];
  int unsigned                  shadow_count;

  stack_result_t expected_results [$];
  int unsigned   sent_count;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   hold_cycles_done;

  // Directed rows: extremes, refused pops, equal minimums, pop back to empty
  stack_row_t directed_rows [NUM_ROWS] = '{
    '{MTS_KIND_POP,  32'sd0,        1'b1, '{32'sd0,  32'sd0,  1'b1, MTS_STATUS_EMPTY}},
    '{MTS_KIND_POP,  32'sh1234_5678, 1'b1, '{32'sd0, 32'sd0,  1'b1, MTS_STATUS_EMPTY}},
    '{MTS_KIND_PUSH, VAL_MAX,       1'b1, '{VAL_MAX, VAL_MAX, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, VAL_MIN,       1'b1, '{VAL_MIN, VAL_MIN, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd0,        1'b1, '{32'sd0,  VAL_MIN, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, VAL_NEG,       1'b1, '{VAL_NEG, VAL_MIN, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  VAL_NEG,       1'b1, '{32'sd0,  VAL_MIN, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b1, '{VAL_MIN, VAL_MIN, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  VAL_MAX,       1'b1, '{VAL_MAX, VAL_MAX, 1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  VAL_MIN,       1'b1, '{32'sd0,  32'sd0,  1'b1, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd5,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd5,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd3,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd3,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_PUSH, 32'sd7,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b0, '{32'sd0,  32'sd0,  1'b0, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b1, '{32'sd0,  32'sd0,  1'b1, MTS_STATUS_OK}},
    '{MTS_KIND_POP,  32'sd0,        1'b1, '{32'sd0,  32'sd0,  1'b1, MTS_STATUS_EMPTY}},
    '{MTS_KIND_PUSH, 32'sh5555_5555, 1'b0, '{32'sd0, 32'sd0,  1'b0, MTS_STATUS_OK}}
  };

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Advance the shadow stack by one operation and return what the block must report
  function automatic stack_result_t min_stack_predict(input logic kind,
                                                      input logic signed [MTS_DATA_W-1:0] v);
    stack_result_t                res;
    logic signed [MTS_DATA_W-1:0] new_min;
    res.status = MTS_STATUS_OK;
    if (kind == MTS_KIND_PUSH) begin
      if (shadow_count >= MTS_STACK_DEPTH) begin
        res.status = MTS_STATUS_FULL;
      end else begin
        new_min = v;
        // An equal value keeps the older minimum; comparison is signed
        if (shadow_count > 0 && shadow_minimums[shadow_count-1] <= v) begin
          new_min = shadow_minimums[shadow_count-1];
        end
        shadow_values[shadow_count]   = v;
        shadow_minimums[shadow_count] = new_min;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = MTS_STATUS_EMPTY;
    end else begin
      shadow_count--;
    end
    if (shadow_count > 0) begin
      res.top_value = shadow_values[shadow_count-1];
      res.min_value = shadow_minimums[shadow_count-1];
      res.is_empty  = 1'b0;
    end else begin
      res.top_value = '0;
      res.min_value = '0;
      res.is_empty  = 1'b1;
    end
    return res;
  endfunction

  function automatic logic calm_window();
    return (sent_count >= CALM_FIRST && sent_count < CALM_LAST);
  endfunction

  // Mix of full-range values, small values that collide, extremes, and values
  // close to the current minimum so that ties and near misses are common
  function automatic logic signed [MTS_DATA_W-1:0] pick_value();
    logic signed [MTS_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: v = $signed($urandom_range(0, 16)) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = VAL_NEG;
        endcase
      end
      default: begin
        if (shadow_count > 0) begin
          v = shadow_minimums[shadow_count-1] + ($signed($urandom_range(0, 4)) - 2);
        end else begin
          v = $urandom;
        end
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [MTS_DATA_W-1:0] got,
                                 input logic [MTS_DATA_W-1:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Offer one item, starting at a falling edge, and hold it until the transfer.
  // Returns at the falling edge after the transfer. known_result selects the
  // typed-in expectation over the shadow stack's, which still advances.
  task automatic offer_item(input logic kind, input logic signed [MTS_DATA_W-1:0] v,
                            input logic known_result, input stack_result_t typed);
    stack_result_t predicted;
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= v;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    predicted = min_stack_predict(kind, v);
    expected_results.push_back(known_result ? typed : predicted);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Receiver: random backpressure, a calm window, and one long hold-off
  initial begin
    out_ch.ready     = 1'b0;
    hold_cycles_done = 0;
    forever begin
      @(negedge clk_i);
      if (sent_count >= HOLD_AT_ITEM && hold_cycles_done < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        hold_cycles_done++;
      end else if (calm_window()) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Check every output transfer against the oldest pending expectation
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.top_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.top_value !== want.top_value)
          report_mismatch("top_value", out_ch.top_value, want.top_value);
        if (out_ch.min_value !== want.min_value)
          report_mismatch("min_value", out_ch.min_value, want.min_value);
        if (out_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_ch.is_empty), 32'(want.is_empty));
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
      end
    end
  end

  // Bound the run in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_min_tracking_stack_top: FAIL");
      $finish;
    end
  end

  initial begin
    phase_e      phase;
    int unsigned phase_len;
    int unsigned push_percent;
    int unsigned phase_index;
    logic        kind;
    logic        paused;

    in_ch.valid    = 1'b0;
    in_ch.kind     = MTS_KIND_PUSH;
    in_ch.value    = '0;
    rst_ni         = 1'b0;
    shadow_count   = 0;
    sent_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    paused         = 1'b0;
    phase_index    = 0;

    // Hold reset, then release it away from the rising edge
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      offer_item(directed_rows[r].kind, directed_rows[r].value,
                 directed_rows[r].known_result, directed_rows[r].result);
    end

    // Random phases. Open with a fill past full and a drain past empty so
    // both refusals show up early, then pick phases at random.
    while (sent_count < NUM_ROWS + RANDOM_ITEMS) begin
      case (phase_index)
        0: phase = PH_TO_FULL;
        1: phase = PH_TO_EMPTY;
        default: phase = phase_e'($urandom_range(0, 4));
      endcase
      phase_index++;
      case (phase)
        PH_TO_FULL:  phase_len = MTS_STACK_DEPTH - shadow_count + $urandom_range(1, 4);
        PH_TO_EMPTY: phase_len = shadow_count + $urandom_range(1, 4);
        default:     phase_len = $urandom_range(20, 120);
      endcase
      case (phase)
        PH_TO_FULL:    push_percent = 100;
        PH_TO_EMPTY:   push_percent = 0;
        PH_PUSH_HEAVY: push_percent = 85;
        PH_POP_HEAVY:  push_percent = 15;
        default:       push_percent = 50;
      endcase
      for (int unsigned i = 0; i < phase_len; i++) begin
        // Drop valid and wait for every pending result once
        if (!paused && sent_count >= PAUSE_AT_ITEM) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          do begin
            @(negedge clk_i);
          end while (expected_results.size() != 0);
        end
        kind = ($urandom_range(0, 99) < push_percent) ? MTS_KIND_PUSH : MTS_KIND_POP;
        offer_item(kind, pick_value(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_min_tracking_stack_top: PASS");
    end else begin
      $display("tb_min_tracking_stack_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mts_pkg.sv
rtl/mts_if.sv
rtl/mts_ram.sv
rtl/mts_core.sv
rtl/min_tracking_stack_top.sv
rtl/mts_checker.sv
tb/tb_min_tracking_stack_top.sv
